// ===== rtl/mcs_pkg.sv =====
// Shared codes, widths and types of the multigroup collision sampler.
package mcs_pkg;

    localparam int XS_W    = 32;
    localparam int NUBAR_W = 24;
    localparam int PROB_W  = 17;
    localparam int GRP_W   = 7;
    localparam int CNT_W   = 8;
    localparam int U_W     = 16;

    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_COLLISION = 2'd1;
    localparam logic [1:0] KIND_DRAW      = 2'd2;

    localparam logic [2:0] SEL_CAPTURE = 3'd0;
    localparam logic [2:0] SEL_FISSION = 3'd2;
    localparam logic [2:0] SEL_NUBAR   = 3'd3;
    localparam logic [2:0] SEL_SCATTER = 3'd4;
    localparam logic [2:0] SEL_CHI     = 3'd5;

    localparam logic [2:0] EV_CAPTURE   = 3'd0;
    localparam logic [2:0] EV_SCATTER   = 3'd1;
    localparam logic [2:0] EV_FISSION   = 3'd2;
    localparam logic [2:0] EV_NONE      = 3'd3;
    localparam logic [2:0] EV_SECONDARY = 3'd4;
    localparam logic [2:0] EV_FAILED    = 3'd5;

    localparam logic REG_GROUP_COUNT = 1'b0;

    typedef struct packed {
        logic       we_scatter;
        logic       we_chi;
        logic       rd_chi;
    } prob_ctl_t;

endpackage

// ===== rtl/mcs_prob_mem.sv =====
// Scatter and chi probability memories with one write and one registered read.
module mcs_prob_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       aclk,
    input  mcs_pkg::prob_ctl_t         ctl,
    input  logic [AW-1:0]              wr_addr,
    input  logic [mcs_pkg::PROB_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [mcs_pkg::PROB_W-1:0] rd_data
);
    import mcs_pkg::*;

    logic [PROB_W-1:0] scatter_mem [DEPTH];
    logic [PROB_W-1:0] chi_mem [DEPTH];
    logic [PROB_W-1:0] scatter_rd_reg;
    logic [PROB_W-1:0] chi_rd_reg;
    logic              sel_chi_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we_scatter) begin
            scatter_mem[wr_addr] <= wr_data;
        end
        scatter_rd_reg <= scatter_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.we_chi) begin
            chi_mem[wr_addr] <= wr_data;
        end
        chi_rd_reg <= chi_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        sel_chi_reg <= ctl.rd_chi;
    end

    assign rd_data = sel_chi_reg ? chi_rd_reg : scatter_rd_reg;

endmodule

// ===== rtl/multigroup_collision_sampler.sv =====
// Top level of the multigroup collision sampler: sequencer, tables and result stage.
// A table write ends on acceptance; a collision reads its cross sections, forms
// its threshold and picks a reaction, then walks the active groups for a scatter;
// a draw walks the chi column. The walk reads one probability entry per cycle.
// One request in flight at a time; a finished result waits in the output register.
// Reset (aresetn, synchronous, low): idle, nothing pending, fission group 1,
// group_count 1. Tables are not cleared and must be written before use.
module multigroup_collision_sampler #(
    parameter int MAX_GROUPS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [2:0]  s_table_select,
    input  logic [6:0]  s_row,
    input  logic [6:0]  s_col,
    input  logic [31:0] s_write_value,
    input  logic [6:0]  s_group,
    input  logic [15:0] s_u_first,
    input  logic [15:0] s_u_second,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [6:0]  m_out_group,
    output logic [7:0]  m_yield_count,
    output logic [7:0]  m_remaining,
    output logic        m_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcs_pkg::*;

    localparam int IW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int XS_DEPTH = 3 * MAX_GROUPS;
    localparam int XW       = $clog2(XS_DEPTH);
    localparam int P_DEPTH  = MAX_GROUPS * MAX_GROUPS;
    localparam int PW       = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam logic [8:0] MAXG = 9'(MAX_GROUPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_XRD   = 3'd1;
    localparam logic [2:0] S_THR   = 3'd2;
    localparam logic [2:0] S_REACT = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // ---------------- configuration ----------------
    logic [6:0] gc_reg, gc_next;
    logic [8:0] n_act;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GROUP_COUNT) ? {25'd0, gc_reg} : 32'd0;
    assign n_act  = ({2'b0, gc_reg} < MAXG) ? {2'b0, gc_reg} : MAXG;

    always_comb begin
        gc_next = gc_reg;
        if (psel && penable && pwrite && paddr[2] == REG_GROUP_COUNT) begin
            gc_next = pwdata[6:0];
        end
    end

    // ---------------- sequencer registers ----------------
    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     grp_idx_reg, grp_idx_next;
    logic [6:0]        grp_reg, grp_next;
    logic [15:0]       u1_reg, u1_next;
    logic [15:0]       u2_reg, u2_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [XS_W-1:0]   xs_val_reg [3];
    logic [XS_W-1:0]   xs_val_next [3];
    logic [33:0]       total_reg, total_next;
    logic [49:0]       thr_reg, thr_next;
    logic [33:0]       racc_reg, racc_next;
    logic [7:0]        pend_reg, pend_next;
    logic [6:0]        fgrp_reg, fgrp_next;
    logic              walk_chi_reg, walk_chi_next;
    logic [IW-1:0]     walk_col_reg, walk_col_next;
    logic [8:0]        walk_idx_reg, walk_idx_next;
    logic [8:0]        didx_reg, didx_next;
    logic              dv_reg, dv_next;
    logic [25:0]       wacc_reg, wacc_next;
    logic [15:0]       wu_reg, wu_next;
    // pending result
    logic [2:0]        res_ev_reg, res_ev_next;
    logic [6:0]        res_grp_reg, res_grp_next;
    logic [7:0]        res_yc_reg, res_yc_next;
    logic [7:0]        res_rem_reg, res_rem_next;
    logic              res_last_reg, res_last_next;
    // output stage
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_ev_reg;
    logic [6:0]        m_grp_reg;
    logic [7:0]        m_yc_reg;
    logic [7:0]        m_rem_reg;
    logic              m_last_reg;

    // ---------------- tables ----------------
    logic [XS_W-1:0]    xs_mem [XS_DEPTH];
    logic [XS_W-1:0]    xs_rd_reg;
    logic [NUBAR_W-1:0] nubar_mem [MAX_GROUPS];
    logic [NUBAR_W-1:0] nubar_rd_reg;
    logic [PROB_W-1:0]  prob_rd;
    prob_ctl_t          pctl;

    logic          accept;
    logic          row_ok, col_ok;
    logic [IW-1:0] row_idx, col_idx;
    logic [XW-1:0] xs_waddr, xs_raddr;
    logic [PW-1:0] p_waddr, p_raddr;
    logic          xs_we, nubar_we;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign row_ok  = (s_row != 7'd0) && ({2'b0, s_row} <= MAXG);
    assign col_ok  = (s_col != 7'd0) && ({2'b0, s_col} <= MAXG);
    assign row_idx = IW'(s_row - 7'd1);
    assign col_idx = IW'(s_col - 7'd1);

    assign xs_we    = accept && s_kind == KIND_WRITE && row_ok && s_table_select < SEL_NUBAR;
    assign nubar_we = accept && s_kind == KIND_WRITE && row_ok && s_table_select == SEL_NUBAR;
    assign xs_waddr = XW'(XW'(s_table_select[1:0]) * XW'(MAX_GROUPS) + XW'(row_idx));
    assign xs_raddr = XW'(XW'(cnt_reg) * XW'(MAX_GROUPS) + XW'(grp_idx_reg));
    assign p_waddr  = PW'(PW'(col_idx) * PW'(MAX_GROUPS) + PW'(row_idx));
    assign p_raddr  = PW'(PW'(walk_col_reg) * PW'(MAX_GROUPS) + PW'(walk_idx_reg[IW-1:0]));

    assign pctl.we_scatter = accept && s_kind == KIND_WRITE && row_ok && col_ok
                             && s_table_select == SEL_SCATTER;
    assign pctl.we_chi     = accept && s_kind == KIND_WRITE && row_ok && col_ok
                             && s_table_select == SEL_CHI;
    assign pctl.rd_chi     = walk_chi_reg;

    always_ff @(posedge aclk) begin
        if (xs_we) begin
            xs_mem[xs_waddr] <= s_write_value;
        end
        xs_rd_reg <= xs_mem[xs_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nubar_we) begin
            nubar_mem[row_idx] <= s_write_value[NUBAR_W-1:0];
        end
        nubar_rd_reg <= nubar_mem[grp_idx_reg];
    end

    mcs_prob_mem #(
        .DEPTH (P_DEPTH),
        .AW    (PW)
    ) u_prob_mem (
        .aclk    (aclk),
        .ctl     (pctl),
        .wr_addr (p_waddr),
        .wr_data (s_write_value[PROB_W-1:0]),
        .rd_addr (p_raddr),
        .rd_data (prob_rd)
    );

    // ---------------- shared step logic ----------------
    logic [33:0] racc_sum;
    logic        react_hit;
    logic [8:0]  yld_raw;
    logic [7:0]  yld;
    logic [25:0] wsum;
    logic [6:0]  fcol;
    logic        grp_ok;

    assign racc_sum  = racc_reg + {2'b0, xs_val_reg[cnt_reg]};
    assign react_hit = {racc_sum, 16'd0} > thr_reg;
    assign yld_raw   = 9'(({1'b0, nubar_rd_reg} + {9'd0, u2_reg}) >> 16);
    assign yld       = yld_raw[8] ? 8'hFF : yld_raw[7:0];
    assign wsum      = wacc_reg + {9'd0, prob_rd};
    // fall back to group 1 when the stored fission group is out of range
    assign fcol      = (fgrp_reg == 7'd0 || {2'b0, fgrp_reg} > MAXG) ? 7'd1 : fgrp_reg;
    assign grp_ok    = (s_group != 7'd0) && ({2'b0, s_group} <= n_act);

    always_comb begin
        state_next    = state_reg;
        grp_idx_next  = grp_idx_reg;
        grp_next      = grp_reg;
        u1_next       = u1_reg;
        u2_next       = u2_reg;
        cnt_next      = cnt_reg;
        xs_val_next   = xs_val_reg;
        total_next    = total_reg;
        thr_next      = thr_reg;
        racc_next     = racc_reg;
        pend_next     = pend_reg;
        fgrp_next     = fgrp_reg;
        walk_chi_next = walk_chi_reg;
        walk_col_next = walk_col_reg;
        walk_idx_next = walk_idx_reg;
        didx_next     = didx_reg;
        dv_next       = 1'b0;
        wacc_next     = wacc_reg;
        wu_next       = wu_reg;
        res_ev_next   = res_ev_reg;
        res_grp_next  = res_grp_reg;
        res_yc_next   = res_yc_reg;
        res_rem_next  = res_rem_reg;
        res_last_next = res_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    grp_next     = s_group;
                    grp_idx_next = IW'(s_group - 7'd1);
                    u1_next      = s_u_first;
                    u2_next      = s_u_second;
                    res_grp_next  = 7'd0;
                    res_yc_next   = 8'd0;
                    res_rem_next  = 8'd0;
                    res_last_next = 1'b0;
                    if (s_kind == KIND_COLLISION) begin
                        // a new collision drops any draws still pending
                        pend_next = 8'd0;
                        if (grp_ok) begin
                            cnt_next   = 2'd0;
                            total_next = 34'd0;
                            state_next = S_XRD;
                        end else begin
                            res_ev_next = EV_NONE;
                            state_next  = S_OUT;
                        end
                    end else if (s_kind == KIND_DRAW && pend_reg != 8'd0) begin
                        walk_chi_next = 1'b1;
                        walk_col_next = IW'(fcol - 7'd1);
                        walk_idx_next = 9'd0;
                        wacc_next     = 26'd0;
                        wu_next       = s_u_first;
                        state_next    = S_WALK;
                    end
                end
            end
            S_XRD: begin
                // issue capture, scatter, fission reads; collect each in the cycle after its read
                if (cnt_reg != 2'd0) begin
                    xs_val_next[cnt_reg - 2'd1] = xs_rd_reg;
                    total_next = total_reg + {2'b0, xs_rd_reg};
                end
                if (cnt_reg == 2'd3) begin
                    state_next = S_THR;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            S_THR: begin
                thr_next   = {16'd0, total_reg} * {34'd0, u1_reg};
                racc_next  = 34'd0;
                cnt_next   = 2'd0;
                state_next = S_REACT;
            end
            S_REACT: begin
                racc_next = racc_sum;
                if (react_hit && cnt_reg == 2'd0) begin
                    res_ev_next = EV_CAPTURE;
                    state_next  = S_OUT;
                end else if (react_hit && cnt_reg == 2'd1) begin
                    walk_chi_next = 1'b0;
                    walk_col_next = grp_idx_reg;
                    walk_idx_next = 9'd0;
                    wacc_next     = 26'd0;
                    wu_next       = u2_reg;
                    state_next    = S_WALK;
                end else if (react_hit) begin
                    pend_next    = yld;
                    fgrp_next    = grp_reg;
                    res_ev_next  = EV_FISSION;
                    res_yc_next  = yld;
                    res_rem_next = yld;
                    state_next   = S_OUT;
                end else if (cnt_reg == 2'd2) begin
                    res_ev_next = EV_NONE;
                    state_next  = S_OUT;
                end else begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            S_WALK: begin
                // one entry read per cycle, data checked in the cycle after its read
                if (walk_idx_reg < n_act) begin
                    walk_idx_next = walk_idx_reg + 9'd1;
                    dv_next       = 1'b1;
                end
                didx_next = walk_idx_reg;
                if (n_act == 9'd0 || (dv_reg && (wsum > {10'd0, wu_reg}
                        || didx_reg + 9'd1 == n_act))) begin
                    if (n_act != 9'd0 && wsum > {10'd0, wu_reg}) begin
                        res_grp_next = 7'(didx_reg + 9'd1);
                        res_ev_next  = walk_chi_reg ? EV_SECONDARY : EV_SCATTER;
                    end else begin
                        res_grp_next = 7'd0;
                        res_ev_next  = EV_FAILED;
                    end
                    if (walk_chi_reg) begin
                        pend_next     = pend_reg - 8'd1;
                        res_rem_next  = pend_reg - 8'd1;
                        res_last_next = (pend_reg == 8'd1);
                    end
                    dv_next    = 1'b0;
                    state_next = S_OUT;
                end else if (dv_reg) begin
                    wacc_next = wsum;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = (state_reg == S_OUT && (!m_valid_reg || m_ready)) ? 1'b1
                        : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            gc_reg      <= 7'd1;
            pend_reg    <= 8'd0;
            fgrp_reg    <= 7'd1;
            m_valid_reg <= 1'b0;
            dv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gc_reg      <= gc_next;
            pend_reg    <= pend_next;
            fgrp_reg    <= fgrp_next;
            m_valid_reg <= m_valid_next;
            dv_reg      <= dv_next;
        end
    end

    always_ff @(posedge aclk) begin
        grp_idx_reg   <= grp_idx_next;
        grp_reg       <= grp_next;
        u1_reg        <= u1_next;
        u2_reg        <= u2_next;
        cnt_reg       <= cnt_next;
        xs_val_reg    <= xs_val_next;
        total_reg     <= total_next;
        thr_reg       <= thr_next;
        racc_reg      <= racc_next;
        walk_chi_reg  <= walk_chi_next;
        walk_col_reg  <= walk_col_next;
        walk_idx_reg  <= walk_idx_next;
        didx_reg      <= didx_next;
        wacc_reg      <= wacc_next;
        wu_reg        <= wu_next;
        res_ev_reg    <= res_ev_next;
        res_grp_reg   <= res_grp_next;
        res_yc_reg    <= res_yc_next;
        res_rem_reg   <= res_rem_next;
        res_last_reg  <= res_last_next;
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            m_ev_reg   <= res_ev_reg;
            m_grp_reg  <= res_grp_reg;
            m_yc_reg   <= res_yc_reg;
            m_rem_reg  <= res_rem_reg;
            m_last_reg <= res_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_res   = m_ev_reg;
    assign m_out_group   = m_grp_reg;
    assign m_yield_count = m_yc_reg;
    assign m_remaining   = m_rem_reg;
    assign m_last        = m_last_reg;

    // ---------------- checks ----------------
    a_busy_after_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_kind == KIND_COLLISION |=> !s_ready)
        else $error("collision accepted without leaving idle");

    a_fission_yield: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_FISSION |-> m_yield_count == m_remaining)
        else $error("fission yield and remaining count differ");

    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_remaining == 8'd0
            && (m_event_res == EV_SECONDARY || m_event_res == EV_FAILED))
        else $error("last flag on a wrong result");

    a_group_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_group != 7'd0
            |-> (m_event_res == EV_SCATTER || m_event_res == EV_SECONDARY))
        else $error("group reported on a result that has none");

endmodule

// ===== verif/tb_multigroup_collision_sampler.sv =====
// Self-checking testbench for the multigroup collision sampler.
`timescale 1ns / 1ps

module tb_multigroup_collision_sampler;
    import mcs_pkg::*;

    localparam int NG         = 64;
    localparam int DRAIN      = 80;    // longest walk plus result stage, rounded up
    localparam int STALL_LEN  = 400;   // long receiver hold-off
    localparam int DOG_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int PHASE_REQS = 110;

    // Codes the package does not name.
    localparam logic [2:0] SEL_SCAT_XS = 3'd1;
    localparam logic [2:0] SEL_BAD_LO  = 3'd6;
    localparam logic [2:0] SEL_BAD_HI  = 3'd7;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  sel;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [31:0] wval;
        logic [6:0]  grp;
        logic [15:0] u1;
        logic [15:0] u2;
    } req_t;

    typedef struct packed {
        logic [2:0] ev;
        logic [6:0] grp;
        logic [7:0] yc;
        logic [7:0] rem;
        logic       last;
    } event_t;

    typedef struct packed {
        req_t   r;
        logic   typed;
        event_t e;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [2:0]  s_table_select;
    logic [6:0]  s_row;
    logic [6:0]  s_col;
    logic [31:0] s_write_value;
    logic [6:0]  s_group;
    logic [15:0] s_u_first;
    logic [15:0] s_u_second;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_event_res;
    logic [6:0]  m_out_group;
    logic [7:0]  m_yield_count;
    logic [7:0]  m_remaining;
    logic        m_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multigroup_collision_sampler dut (.*);

    // Shadow copy of the block's tables and sequencer state.
    logic [31:0] xs_mem    [0:2][1:NG];
    logic [23:0] nubar_mem [1:NG];
    logic [16:0] scat_mem  [1:NG][1:NG];   // [incident column][outgoing row]
    logic [16:0] chi_mem   [1:NG][1:NG];
    bit          xs_ok     [0:2][1:NG];
    bit          nubar_ok  [1:NG];
    bit          scat_ok   [1:NG][1:NG];
    bit          chi_ok    [1:NG][1:NG];
    int unsigned pend_draws;
    int unsigned fiss_grp;
    int unsigned group_cfg;

    event_t   expected_events[$];
    dir_row_t dir_tab[$];
    bit       failed;
    bit       quiet;      // no random idling on either side
    bit       hold_req;   // asks the receiver for one long hold-off
    int       idle_cycles;

    function automatic int unsigned active_groups();
        return (group_cfg < NG) ? group_cfg : NG;
    endfunction

    // First outgoing group whose running sum exceeds u, else 0.
    function automatic int unsigned walk_column(bit use_chi, int unsigned inc,
                                                logic [15:0] u);
        longint unsigned acc;
        acc = 0;
        for (int unsigned g = 1; g <= active_groups(); g++) begin
            acc += use_chi ? chi_mem[inc][g] : scat_mem[inc][g];
            if (acc > u) return g;
        end
        return 0;
    endfunction

    function automatic event_t mk_event(logic [2:0] ev, int unsigned grp, int unsigned yc,
                                        int unsigned rem, bit last);
        event_t e;
        e.ev = ev; e.grp = grp[6:0]; e.yc = yc[7:0]; e.rem = rem[7:0]; e.last = last;
        return e;
    endfunction

    // Advance the shadow state by one accepted request; return 1 if it yields an event.
    function automatic bit predict_collision(req_t r, output event_t e);
        longint unsigned xs [3];
        longint unsigned total, thr, acc;
        int unsigned     ri, g, y;
        e = '0;
        case (r.kind)
            KIND_WRITE: begin
                if (r.row < 1 || r.row > NG) return 0;
                if (r.sel <= SEL_FISSION) begin
                    xs_mem[r.sel][r.row] = r.wval;
                    xs_ok[r.sel][r.row]  = 1;
                end else if (r.sel == SEL_NUBAR) begin
                    nubar_mem[r.row] = r.wval[23:0];
                    nubar_ok[r.row]  = 1;
                end else if (r.sel == SEL_SCATTER || r.sel == SEL_CHI) begin
                    if (r.col < 1 || r.col > NG) return 0;
                    if (r.sel == SEL_SCATTER) begin
                        scat_mem[r.col][r.row] = r.wval[16:0];
                        scat_ok[r.col][r.row]  = 1;
                    end else begin
                        chi_mem[r.col][r.row] = r.wval[16:0];
                        chi_ok[r.col][r.row]  = 1;
                    end
                end
                return 0;
            end
            KIND_COLLISION: begin
                pend_draws = 0;
                if (r.grp < 1 || r.grp > active_groups()) begin
                    e = mk_event(EV_NONE, 0, 0, 0, 0);
                    return 1;
                end
                for (int k = 0; k < 3; k++) xs[k] = xs_mem[k][r.grp];
                total = xs[0] + xs[1] + xs[2];
                thr   = longint'(r.u1) * total;
                acc   = 0;
                for (ri = 0; ri < 3; ri++) begin
                    acc += xs[ri];
                    if ((acc << 16) > thr) break;
                end
                if (ri == 0) begin
                    e = mk_event(EV_CAPTURE, 0, 0, 0, 0);
                end else if (ri == 1) begin
                    g = walk_column(0, r.grp, r.u2);
                    e = (g != 0) ? mk_event(EV_SCATTER, g, 0, 0, 0)
                                 : mk_event(EV_FAILED, 0, 0, 0, 0);
                end else if (ri == 2) begin
                    y = (nubar_mem[r.grp] + r.u2) >> 16;
                    if (y > 255) y = 255;
                    pend_draws = y;
                    fiss_grp   = r.grp;
                    e = mk_event(EV_FISSION, 0, y, y, 0);
                end else begin
                    e = mk_event(EV_NONE, 0, 0, 0, 0);
                end
                return 1;
            end
            KIND_DRAW: begin
                if (pend_draws == 0) return 0;
                g = walk_column(1, fiss_grp, r.u1);
                pend_draws--;
                e = mk_event((g != 0) ? EV_SECONDARY : EV_FAILED, g, 0, pend_draws,
                             pend_draws == 0);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // Request builders.
    function automatic req_t wr(logic [2:0] sel, int unsigned row, int unsigned col,
                                logic [31:0] val);
        req_t r;
        r = '0; r.kind = KIND_WRITE; r.sel = sel; r.row = row; r.col = col; r.wval = val;
        return r;
    endfunction

    function automatic req_t hit(int unsigned grp, logic [15:0] u1, logic [15:0] u2);
        req_t r;
        r = '0; r.kind = KIND_COLLISION; r.grp = grp; r.u1 = u1; r.u2 = u2;
        return r;
    endfunction

    function automatic req_t drw(logic [15:0] u1);
        req_t r;
        r = '0; r.kind = KIND_DRAW; r.u1 = u1;
        return r;
    endfunction

    function automatic req_t noise_req();
        req_t r;
        r.kind = $urandom_range(3);
        r.sel  = $urandom; r.row = $urandom; r.col = $urandom;
        r.wval = $urandom; r.u1 = $urandom; r.u2 = $urandom;
        r.grp  = ($urandom_range(1)) ? 7'd0 : 7'($urandom_range(active_groups() + 1, 127));
        // keep valid-address writes and in-range collisions out of the noise
        if (r.kind == KIND_WRITE) r.sel = SEL_BAD_LO + $urandom_range(1);
        if (r.kind == KIND_DRAW && pend_draws != 0) r.kind = KIND_BAD;
        return r;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Offer one request, hold it until accepted, then predict.
    task automatic send_request(req_t r, bit typed = 0, event_t te = '0);
        event_t e;
        if (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= r.kind;
        s_table_select <= r.sel;
        s_row          <= r.row;
        s_col          <= r.col;
        s_write_value  <= r.wval;
        s_group        <= r.grp;
        s_u_first      <= r.u1;
        s_u_second     <= r.u2;
        do @(posedge aclk); while (!s_ready);
        if (predict_collision(r, e)) expected_events.push_back(typed ? te : e);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(bit wr_en, logic [31:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr_en;
        paddr   <= {REG_GROUP_COUNT, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program group_count and read it back; block must be idle.
    task automatic set_group_count(int unsigned n);
        logic [31:0] rd;
        wait_drained();
        repeat (DRAIN) @(posedge aclk);
        apb_access(1, n, rd);
        group_cfg = n;
        apb_access(0, 0, rd);
        if (rd[6:0] !== n[6:0]) begin
            $display("%0t group_count readback: expected %0d actual %0d", $time, n, rd[6:0]);
            failed = 1;
        end
    endtask

    // Write every entry a collision on grp or its draws may read, if not yet written.
    task automatic fill_group(int unsigned grp);
        int unsigned n, pmax;
        n    = active_groups();
        pmax = (2 * 65536) / n;
        for (int s = 0; s < 3; s++)
            if (!xs_ok[s][grp])
                send_request(wr(s, grp, 0, ($urandom_range(7) == 0) ? 32'd0 :
                                           ($urandom_range(1) ? $urandom : $urandom_range(1 << 20))));
        if (!nubar_ok[grp])
            send_request(wr(SEL_NUBAR, grp, 0, ($urandom_range(29) == 0) ? $urandom
                                                : $urandom_range(3 << 16)));
        for (int unsigned g = 1; g <= n; g++) begin
            if (!scat_ok[grp][g]) send_request(wr(SEL_SCATTER, g, grp, $urandom_range(pmax)));
            if (!chi_ok[grp][g])  send_request(wr(SEL_CHI, g, grp, $urandom_range(pmax)));
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t unexpected result: expected none actual ev=%0d grp=%0d",
                         $time, m_event_res, m_out_group);
                failed = 1;
            end else begin
                want = expected_events.pop_front();
                if (m_event_res !== want.ev) begin
                    $display("%0t event_res: expected %0d actual %0d", $time, want.ev, m_event_res);
                    failed = 1;
                end
                if (m_out_group !== want.grp) begin
                    $display("%0t out_group: expected %0d actual %0d", $time, want.grp, m_out_group);
                    failed = 1;
                end
                if (m_yield_count !== want.yc) begin
                    $display("%0t yield_count: expected %0d actual %0d", $time, want.yc,
                             m_yield_count);
                    failed = 1;
                end
                if (m_remaining !== want.rem) begin
                    $display("%0t remaining: expected %0d actual %0d", $time, want.rem, m_remaining);
                    failed = 1;
                end
                if (m_last !== want.last) begin
                    $display("%0t last: expected %0d actual %0d", $time, want.last, m_last);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: any handshake on any port resets the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > DOG_LIMIT) begin
            $display("multigroup_collision_sampler: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned phase_n [5] = '{4, 64, 127, 8, 1};
        int unsigned pool [3];
        int unsigned pick, neff;
        logic [31:0] ones;

        ones = 32'hFFFF_FFFF;
        aresetn = 1'b0;
        s_valid = 1'b0; s_kind = '0; s_table_select = '0; s_row = '0; s_col = '0;
        s_write_value = '0; s_group = '0; s_u_first = '0; s_u_second = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        failed = 0; quiet = 0; hold_req = 0; idle_cycles = 0;
        pend_draws = 0; fiss_grp = 1; group_cfg = 1;
        for (int s = 0; s < 3; s++) for (int g = 1; g <= NG; g++) begin
            xs_mem[s][g] = '0; xs_ok[s][g] = 0;
        end
        for (int c = 1; c <= NG; c++) begin
            nubar_mem[c] = '0; nubar_ok[c] = 0;
            for (int g = 1; g <= NG; g++) begin
                scat_mem[c][g] = '0; chi_mem[c][g] = '0;
                scat_ok[c][g] = 0;   chi_ok[c][g] = 0;
            end
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, group_count still at its reset value of 1.
        // Typed rows: results that follow directly from the extremes written.
        dir_tab.push_back('{hit(0, 0, 0), 1, mk_event(EV_NONE, 0, 0, 0, 0)});
        dir_tab.push_back('{hit(2, 0, 0), 1, mk_event(EV_NONE, 0, 0, 0, 0)});
        dir_tab.push_back('{drw(0), 0, '0});                       // nothing pending: dropped
        dir_tab.push_back('{noise_req(), 0, '0});
        dir_tab.push_back('{wr(SEL_CAPTURE, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_SCAT_XS, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_FISSION, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_NUBAR, 1, 0, ones), 0, '0});
        dir_tab.push_back('{wr(SEL_SCATTER, 1, 1, ones), 0, '0});
        dir_tab.push_back('{wr(SEL_CHI, 1, 1, ones), 0, '0});
        // all cross sections zero: reaction falls through
        dir_tab.push_back('{hit(1, 16'hFFFF, 16'hFFFF), 1, mk_event(EV_NONE, 0, 0, 0, 0)});
        dir_tab.push_back('{wr(SEL_CAPTURE, 1, 0, ones), 0, '0});
        dir_tab.push_back('{hit(1, 16'hFFFF, 0), 1, mk_event(EV_CAPTURE, 0, 0, 0, 0)});
        dir_tab.push_back('{wr(SEL_CAPTURE, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_FISSION, 1, 0, ones), 0, '0});
        // max nubar plus max uniform saturates the yield
        dir_tab.push_back('{hit(1, 0, 16'hFFFF), 1, mk_event(EV_FISSION, 0, 255, 255, 0)});
        dir_tab.push_back('{drw(16'hFFFF), 1, mk_event(EV_SECONDARY, 1, 0, 254, 0)});
        dir_tab.push_back('{wr(SEL_FISSION, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_SCAT_XS, 1, 0, ones), 0, '0});
        // a collision discards the draws still pending
        dir_tab.push_back('{hit(1, 0, 0), 1, mk_event(EV_SCATTER, 1, 0, 0, 0)});
        dir_tab.push_back('{drw(0), 0, '0});
        dir_tab.push_back('{wr(SEL_SCATTER, 1, 1, 0), 0, '0});
        dir_tab.push_back('{hit(1, 0, 16'hFFFF), 1, mk_event(EV_FAILED, 0, 0, 0, 0)});
        // out-of-range write addresses must not land anywhere
        dir_tab.push_back('{wr(SEL_SCATTER, 1, 0, ones), 0, '0});
        dir_tab.push_back('{wr(SEL_SCATTER, 0, 1, ones), 0, '0});
        dir_tab.push_back('{wr(SEL_BAD_HI, 1, 1, ones), 0, '0});
        dir_tab.push_back('{hit(1, 0, 0), 1, mk_event(EV_FAILED, 0, 0, 0, 0)});
        dir_tab.push_back('{wr(SEL_SCAT_XS, 1, 0, 0), 0, '0});
        dir_tab.push_back('{wr(SEL_FISSION, 1, 0, ones), 0, '0});
        dir_tab.push_back('{wr(SEL_NUBAR, 1, 0, 0), 0, '0});
        // zero yield leaves nothing to draw
        dir_tab.push_back('{hit(1, 0, 0), 1, mk_event(EV_FISSION, 0, 0, 0, 0)});
        dir_tab.push_back('{drw(0), 0, '0});
        dir_tab.push_back('{wr(SEL_NUBAR, 1, 0, 32'h0001_0000), 0, '0});
        dir_tab.push_back('{wr(SEL_CHI, 1, 1, 0), 0, '0});
        dir_tab.push_back('{hit(1, 0, 0), 1, mk_event(EV_FISSION, 0, 1, 1, 0)});
        // draw falls through but still counts down to the last one
        dir_tab.push_back('{drw(0), 1, mk_event(EV_FAILED, 0, 0, 0, 1)});
        foreach (dir_tab[i]) send_request(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].e);

        // Random phases, one per group_count setting.
        foreach (phase_n[p]) begin
            set_group_count(phase_n[p]);
            neff = active_groups();
            pool[0] = 1; pool[1] = neff; pool[2] = $urandom_range(1, neff);
            quiet = (p == 1);
            for (int i = 0; i < PHASE_REQS; i++) begin
                if (p == 1 && i == 60) quiet = 0;
                if (p == 0 && i == 40) hold_req = 1;   // long receiver hold-off
                if (p == 0 && i == 80) wait_drained(); // sender pause
                pick = $urandom_range(99);
                if (pick < 10) begin
                    send_request(noise_req());
                end else if (pend_draws != 0 && pick < 75) begin
                    send_request(drw($urandom));
                end else begin
                    pick = pool[$urandom_range(2)];
                    fill_group(pick);
                    send_request(hit(pick, $urandom, $urandom));
                end
            end
            // clear leftover draws so a later, wider setting never walks unwritten rows
            send_request(hit(0, 0, 0));
        end

        wait_drained();
        repeat (DRAIN) @(posedge aclk);
        if (!failed && expected_events.size() == 0)
            $display("multigroup_collision_sampler: match");
        else
            $display("multigroup_collision_sampler: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mcs_pkg.sv
rtl/mcs_prob_mem.sv
rtl/multigroup_collision_sampler.sv
verif/tb_multigroup_collision_sampler.sv
